/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL files that include this header.
// Each macro checks a property on the rising edge of clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true out of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* rtl/y86seq_pkg.sv */
// ----------------------------------------------------------------------------
// y86seq_pkg
// Constants, codes and helper functions of the sequential Y86-64 processor.
// ----------------------------------------------------------------------------
package y86seq_pkg;

	localparam int MEM_BYTES  = 4096;
	localparam int MEM_AW     = $clog2(MEM_BYTES);
	localparam int WORD_BYTES = 8;

	localparam logic [3:0] NO_REG = 4'hF;
	localparam logic [3:0] SP_REG = 4'h4;

	// Request widths on the stream ports.
	localparam int IN_W   = 24;
	localparam int KIND_W = 2;
	localparam int OUT_W  = 280;

	// Request kinds.
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_EXEC = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// Machine status codes.
	localparam logic [1:0] STAT_AOK = 2'd0;
	localparam logic [1:0] STAT_HLT = 2'd1;
	localparam logic [1:0] STAT_ADR = 2'd2;
	localparam logic [1:0] STAT_INS = 2'd3;

	// Instruction codes.
	localparam logic [3:0] I_HALT   = 4'h0;
	localparam logic [3:0] I_NOP    = 4'h1;
	localparam logic [3:0] I_RRMOVQ = 4'h2;
	localparam logic [3:0] I_IRMOVQ = 4'h3;
	localparam logic [3:0] I_RMMOVQ = 4'h4;
	localparam logic [3:0] I_MRMOVQ = 4'h5;
	localparam logic [3:0] I_OPQ    = 4'h6;
	localparam logic [3:0] I_JXX    = 4'h7;
	localparam logic [3:0] I_CALL   = 4'h8;
	localparam logic [3:0] I_RET    = 4'h9;
	localparam logic [3:0] I_PUSHQ  = 4'hA;
	localparam logic [3:0] I_POPQ   = 4'hB;

	// ALU functions.
	localparam logic [3:0] ALU_ADD = 4'h0;
	localparam logic [3:0] ALU_SUB = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;

	// Condition codes of cmov and jump.
	localparam logic [3:0] C_ALL = 4'h0;
	localparam logic [3:0] C_LE  = 4'h1;
	localparam logic [3:0] C_L   = 4'h2;
	localparam logic [3:0] C_E   = 4'h3;
	localparam logic [3:0] C_NE  = 4'h4;
	localparam logic [3:0] C_GE  = 4'h5;
	localparam logic [3:0] C_G   = 4'h6;

	function automatic logic cond_holds(input logic [3:0] fn, input logic zf,
		input logic sf, input logic of);
		logic lt;
		lt = sf ^ of;
		case (fn)
			C_ALL:   cond_holds = 1'b1;
			C_LE:    cond_holds = lt | zf;
			C_L:     cond_holds = lt;
			C_E:     cond_holds = zf;
			C_NE:    cond_holds = ~zf;
			C_GE:    cond_holds = ~lt;
			C_G:     cond_holds = ~lt & ~zf;
			default: cond_holds = 1'b0;
		endcase
	endfunction

endpackage

/* rtl/y86_64_sequential_cpu_top.sv */
// ----------------------------------------------------------------------------
// y86_64_sequential_cpu_top
// Sequential Y86-64 processor with byte-wide memory and a request stream port.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the slave stream (s_tvalid, s_tready, s_tdata,
// s_tuser). The kind in s_tuser selects a memory byte load, the execution of
// one whole instruction, or a register read. Every request gives exactly one
// result on the master stream (m_tvalid, m_tready, m_tdata), which carries
// the status, the pc, the flags, the register and memory writes of the
// instruction and the read data.
// Sequencing. The block works on one request at a time and holds
// s_tready low meanwhile; it is ready again in the cycle the result appears.
// Load, read and unknown requests, and execute requests on a stopped
// machine, go straight to the final step. An instruction is fetched byte
// by byte: the byte-wide memory read port fetches one byte per cycle, a
// data access moves eight more bytes through the same port, and one shared
// 64-bit ALU and one register read port are used in turn.
// Reset. After arst_n is released the block sweeps all 4096 bytes of memory
// to zero, one byte per cycle, before it accepts its first request.
// Stalls. A finished result waits in the output register while m_tready is
// low; the block then holds the next result in its final step.
// ----------------------------------------------------------------------------
module y86_64_sequential_cpu_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// Fields from bit 0 up: address[11:0], load_byte[19:12], zero fill.
	input  logic [y86seq_pkg::IN_W-1:0]   s_tdata,
	// Fields from bit 0 up: kind[1:0].
	input  logic [y86seq_pkg::KIND_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// Fields from bit 0 up: status[1:0], pc[65:2], zero_flag[66],
	// sign_flag[67], overflow_flag[68], reg_write_valid[69],
	// reg_write_index[73:70], reg_write_value[137:74], mem_write_valid[138],
	// mem_write_address[150:139], mem_write_value[214:151],
	// read_data[278:215], zero fill.
	output logic [y86seq_pkg::OUT_W-1:0]  m_tdata
);

	import y86seq_pkg::*;

	`include "assert_macros.svh"

	localparam logic [63:0] MEM_SIZE64 = 64'(MEM_BYTES);
	localparam logic [63:0] MEM_LAST8  = 64'(MEM_BYTES - WORD_BYTES);

	// Sequencer states.
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_F0    = 4'd2;
	localparam logic [3:0] S_F0W   = 4'd3;
	localparam logic [3:0] S_F1    = 4'd4;
	localparam logic [3:0] S_F1W   = 4'd5;
	localparam logic [3:0] S_FC    = 4'd6;
	localparam logic [3:0] S_DA    = 4'd7;
	localparam logic [3:0] S_DB    = 4'd8;
	localparam logic [3:0] S_EXEC  = 4'd9;
	localparam logic [3:0] S_MEM   = 4'd10;
	localparam logic [3:0] S_MRD   = 4'd11;
	localparam logic [3:0] S_MWR   = 4'd12;
	localparam logic [3:0] S_WB1   = 4'd13;
	localparam logic [3:0] S_WB2   = 4'd14;
	localparam logic [3:0] S_DONE  = 4'd15;

	logic [3:0] state_q;

	// Architectural state.
	logic [63:0] rf_q [15];
	logic [63:0] pc_q;
	logic        zf_q, sf_q, of_q;
	logic [1:0]  status_q;

	// Working registers of one instruction.
	logic [63:0] fpc_q;
	logic [3:0]  ic_q, fn_q, ra_q, rb_q;
	logic [63:0] valc_q, vala_q, valb_q, vale_q, valm_q, word_q, wval_q, maddr_q;
	logic        cnd_q;
	logic [3:0]  cnt_q;
	logic [MEM_AW-1:0] clr_q;

	// Result fields collected during the request.
	logic        rwv_q;
	logic [3:0]  rwi_q;
	logic [63:0] rwval_q;
	logic        mwv_q;
	logic [11:0] mwa_q;
	logic [63:0] mwval_q;
	logic [63:0] rdd_q;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	// Request fields.
	logic [1:0]  in_kind;
	logic [11:0] in_addr;
	logic [7:0]  in_byte;
	logic [63:0] in_addr64;
	logic        accept;

	assign in_kind   = s_tuser[1:0];
	assign in_addr   = s_tdata[11:0];
	assign in_byte   = s_tdata[19:12];
	assign in_addr64 = {52'd0, in_addr};
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Decode helpers.
	logic need_const;
	logic [3:0] src_a, src_b;

	always_comb begin
		need_const = ic_q inside {I_IRMOVQ, I_RMMOVQ, I_MRMOVQ, I_JXX, I_CALL};
		src_a = ic_q inside {I_RRMOVQ, I_RMMOVQ, I_OPQ, I_PUSHQ} ? ra_q : NO_REG;
		if (ic_q inside {I_RMMOVQ, I_MRMOVQ, I_OPQ}) begin
			src_b = rb_q;
		end else if (ic_q inside {I_CALL, I_RET, I_PUSHQ, I_POPQ}) begin
			src_b = SP_REG;
		end else begin
			src_b = NO_REG;
		end
	end

	// Single register read port; the no-register code reads as zero.
	logic [3:0]  rf_ridx;
	logic [63:0] rf_rdata;

	always_comb begin
		case (state_q)
			S_IDLE:  rf_ridx = (in_addr < 12'd15) ? in_addr[3:0] : NO_REG;
			S_DA:    rf_ridx = src_a;
			default: rf_ridx = src_b;
		endcase
		rf_rdata = (rf_ridx == NO_REG) ? 64'd0 : rf_q[rf_ridx];
	end

	// Shared ALU. Operand x is always valB; operand y and the function follow
	// the instruction.
	logic [63:0] alu_y, alu_r;
	logic [3:0]  alu_fn;
	logic        alu_of;

	always_comb begin
		case (ic_q)
			I_RMMOVQ, I_MRMOVQ: begin
				alu_y  = valc_q;
				alu_fn = ALU_ADD;
			end
			I_OPQ: begin
				alu_y  = vala_q;
				alu_fn = fn_q;
			end
			I_CALL, I_PUSHQ: begin
				alu_y  = 64'(WORD_BYTES);
				alu_fn = ALU_SUB;
			end
			default: begin
				alu_y  = 64'(WORD_BYTES);
				alu_fn = ALU_ADD;
			end
		endcase
		case (alu_fn)
			ALU_ADD: alu_r = valb_q + alu_y;
			ALU_SUB: alu_r = valb_q - alu_y;
			ALU_AND: alu_r = valb_q & alu_y;
			default: alu_r = valb_q ^ alu_y;
		endcase
		case (alu_fn)
			ALU_ADD: alu_of = (alu_y[63] == valb_q[63]) && (alu_r[63] != alu_y[63]);
			ALU_SUB: alu_of = (alu_y[63] != valb_q[63]) && (alu_r[63] != valb_q[63]);
			default: alu_of = 1'b0;
		endcase
	end

	// Memory ports.
	logic              ram_we;
	logic [MEM_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;
	logic [63:0]       rd_base;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 8'd0;
		case (state_q)
			S_CLEAR: ram_we = 1'b1;
			S_IDLE: begin
				ram_we    = accept && (in_kind == KIND_LOAD) && (in_addr64 < MEM_SIZE64);
				ram_waddr = in_addr64[MEM_AW-1:0];
				ram_wdata = in_byte;
			end
			S_MWR: begin
				ram_we    = 1'b1;
				ram_waddr = maddr_q[MEM_AW-1:0] + MEM_AW'(cnt_q);
				ram_wdata = wval_q[7:0];
			end
			default: ;
		endcase
		rd_base   = (state_q == S_MRD) ? maddr_q : fpc_q;
		ram_raddr = rd_base[MEM_AW-1:0] + MEM_AW'(cnt_q);
	end

	y86seq_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Register write port.
	logic        rf_we;
	logic [3:0]  rf_widx;
	logic [63:0] rf_wval;

	always_comb begin
		rf_we   = 1'b0;
		rf_widx = NO_REG;
		rf_wval = vale_q;
		case (state_q)
			S_WB1: begin
				case (ic_q)
					I_RRMOVQ: begin
						rf_we = cnd_q; rf_widx = rb_q; rf_wval = vala_q;
					end
					I_IRMOVQ: begin
						rf_we = 1'b1; rf_widx = rb_q; rf_wval = valc_q;
					end
					I_OPQ: begin
						rf_we = 1'b1; rf_widx = rb_q;
					end
					I_CALL, I_RET, I_PUSHQ, I_POPQ: begin
						rf_we = 1'b1; rf_widx = SP_REG;
					end
					default: ;
				endcase
			end
			S_WB2: begin
				rf_we   = (ic_q == I_MRMOVQ) || (ic_q == I_POPQ);
				rf_widx = ra_q;
				rf_wval = valm_q;
			end
			default: ;
		endcase
		if (rf_widx == NO_REG) begin
			rf_we = 1'b0;
		end
	end

	logic [63:0] word_next;
	assign word_next = {ram_rdata, word_q[63:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			pc_q       <= 64'd0;
			zf_q       <= 1'b1;
			sf_q       <= 1'b0;
			of_q       <= 1'b0;
			status_q   <= STAT_AOK;
			m_tvalid_q <= 1'b0;
			cnt_q      <= 4'd0;
			for (int i = 0; i < 15; i++) begin
				rf_q[i] <= 64'd0;
			end
		end else begin
			// The final step refills the output itself.
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			if (rf_we) begin
				rf_q[rf_widx] <= rf_wval;
				rwv_q   <= 1'b1;
				rwi_q   <= rf_widx;
				rwval_q <= rf_wval;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MEM_AW'(MEM_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rwv_q   <= 1'b0;
						rwi_q   <= 4'd0;
						rwval_q <= 64'd0;
						mwv_q   <= 1'b0;
						mwa_q   <= 12'd0;
						mwval_q <= 64'd0;
						rdd_q   <= (in_kind == KIND_READ) ? rf_rdata : 64'd0;
						fpc_q   <= pc_q;
						cnt_q   <= 4'd0;
						if (in_kind == KIND_EXEC && status_q == STAT_AOK) begin
							state_q <= S_F0;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_F0: begin
					if (fpc_q >= MEM_SIZE64) begin
						status_q <= STAT_ADR;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_F0W;
					end
				end
				S_F0W: begin
					ic_q <= ram_rdata[7:4];
					fn_q <= ram_rdata[3:0];
					ra_q <= NO_REG;
					rb_q <= NO_REG;
					if (ram_rdata[7:4] > I_POPQ) begin
						status_q <= STAT_INS;
						state_q  <= S_DONE;
					end else if (ram_rdata[7:4] == I_HALT) begin
						status_q <= STAT_HLT;
						state_q  <= S_DONE;
					end else begin
						fpc_q <= fpc_q + 64'd1;
						if (ram_rdata[7:4] inside {I_RRMOVQ, I_IRMOVQ, I_RMMOVQ, I_MRMOVQ,
							I_OPQ, I_PUSHQ, I_POPQ}) begin
							state_q <= S_F1;
						end else if (ram_rdata[7:4] inside {I_JXX, I_CALL}) begin
							state_q <= S_FC;
						end else begin
							state_q <= S_DA;
						end
					end
				end
				S_F1: begin
					if (fpc_q >= MEM_SIZE64) begin
						status_q <= STAT_ADR;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_F1W;
					end
				end
				S_F1W: begin
					ra_q  <= ram_rdata[7:4];
					rb_q  <= ram_rdata[3:0];
					fpc_q <= fpc_q + 64'd1;
					if (ic_q == I_OPQ && fn_q > ALU_XOR) begin
						status_q <= STAT_INS;
						state_q  <= S_DONE;
					end else if (need_const) begin
						state_q <= S_FC;
					end else begin
						state_q <= S_DA;
					end
				end
				S_FC, S_MRD: begin
					// One byte is requested per cycle and the previous one is
					// shifted in, lowest byte first.
					if (cnt_q == 4'd0 && rd_base > MEM_LAST8) begin
						status_q <= STAT_ADR;
						state_q  <= S_DONE;
					end else begin
						if (cnt_q != 4'd0) begin
							word_q <= word_next;
						end
						if (cnt_q == 4'(WORD_BYTES)) begin
							cnt_q <= 4'd0;
							if (state_q == S_FC) begin
								valc_q  <= word_next;
								fpc_q   <= fpc_q + 64'(WORD_BYTES);
								state_q <= S_DA;
							end else begin
								valm_q  <= word_next;
								state_q <= S_WB1;
							end
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
				end
				S_DA: begin
					vala_q  <= rf_rdata;
					state_q <= S_DB;
				end
				S_DB: begin
					valb_q  <= rf_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					vale_q  <= alu_r;
					cnd_q   <= cond_holds(fn_q, zf_q, sf_q, of_q);
					if (ic_q == I_OPQ) begin
						zf_q <= (alu_r == 64'd0);
						sf_q <= alu_r[63];
						of_q <= alu_of;
					end
					state_q <= S_MEM;
				end
				S_MEM: begin
					cnt_q <= 4'd0;
					if (ic_q inside {I_RMMOVQ, I_CALL, I_PUSHQ}) begin
						if (vale_q > MEM_LAST8) begin
							status_q <= STAT_ADR;
							state_q  <= S_DONE;
						end else begin
							wval_q  <= (ic_q == I_CALL) ? fpc_q : vala_q;
							maddr_q <= vale_q;
							mwv_q   <= 1'b1;
							mwa_q   <= vale_q[11:0];
							mwval_q <= (ic_q == I_CALL) ? fpc_q : vala_q;
							state_q <= S_MWR;
						end
					end else if (ic_q == I_MRMOVQ) begin
						maddr_q <= vale_q;
						state_q <= S_MRD;
					end else if (ic_q inside {I_RET, I_POPQ}) begin
						maddr_q <= valb_q;
						state_q <= S_MRD;
					end else begin
						state_q <= S_WB1;
					end
				end
				S_MWR: begin
					wval_q <= {8'd0, wval_q[63:8]};
					if (cnt_q == 4'(WORD_BYTES - 1)) begin
						cnt_q   <= 4'd0;
						state_q <= S_WB1;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_WB1: begin
					case (ic_q)
						I_JXX:   pc_q <= cnd_q ? valc_q : fpc_q;
						I_CALL:  pc_q <= valc_q;
						I_RET:   pc_q <= valm_q;
						default: pc_q <= fpc_q;
					endcase
					state_q <= S_WB2;
				end
				S_WB2: begin
					state_q <= S_DONE;
				end
				default: begin
					// Final step: hand the result over once the output is free.
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, rdd_q, mwval_q, mwa_q, mwv_q, rwval_q, rwi_q,
							rwv_q, of_q, sf_q, zf_q, pc_q, status_q};
						state_q    <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Once stopped, the machine stays stopped until reset.
	`ASSERT_CLK(a_status_sticky, (status_q != STAT_AOK) |=> (status_q != STAT_AOK),
		"status returned to ok")
	// Memory is written only by the sweep, a load request or a store.
	`ASSERT_CLK(a_mem_write_src, ram_we |-> (state_q == S_CLEAR || state_q == S_IDLE ||
		state_q == S_MWR), "unexpected memory write")
	// The no-register code is never written.
	`ASSERT_NEVER(a_no_reg_write, rf_we && rf_widx == NO_REG, "write to register fifteen")
	// No result is produced while the memory is being cleared.
	`ASSERT_NEVER(a_clear_quiet, state_q == S_CLEAR && m_tvalid_q, "result during clear")

endmodule

/* rtl/y86seq_ram.sv */
// ----------------------------------------------------------------------------
// y86seq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module y86seq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
